// ===== hw/rtl/ftbm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftbm_pkg
// Shared widths, defaults and codes for the binomial coefficient core.
// ----------------------------------------------------------------------------
package ftbm_pkg;

    localparam int MOD_W               = 31;
    localparam int TABLE_DEPTH_DEFAULT = 1024;
    localparam int FIELD_W             = 10;

    localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

    localparam logic ACT_PREPARE = 1'b0;
    localparam logic ACT_QUERY   = 1'b1;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_NOT_READY = 1'b1;

    typedef logic [MOD_W-1:0] residue_t;

endpackage

// ===== hw/rtl/factorial_table_binomial_mod_core.sv =====
`timescale 1ns / 1ps
// query: two serial modular multiplies from accept to result
// prepare: a forward factorial pass, the inverse power and a backward inverse pass;
// every step runs through the one shared bit-serial multiplier
// one item at a time; the next item is taken while the result waits on the output
// reset: control cleared, modulus 1000000007, tables not ready, memories not cleared
// ----------------------------------------------------------------------------
// factorial_table_binomial_mod_core
// Factorial and inverse-factorial tables mod a prime, answering C(n,k) queries.
// ----------------------------------------------------------------------------
module factorial_table_binomial_mod_core #(
    parameter int TABLE_DEPTH = ftbm_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [30:0] cfg_wdata,   // modulus
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,     // choose_count[9:0], set_size[19:10], zero pad
    input  logic        s_tuser,     // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // coefficient[30:0], zero pad
    output logic        m_tuser      // status
);
    import ftbm_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_F_GO    = 4'd1;
    localparam logic [3:0] S_F_WAIT  = 4'd2;
    localparam logic [3:0] S_P_CHK   = 4'd3;
    localparam logic [3:0] S_P_MWAIT = 4'd4;
    localparam logic [3:0] S_P_SWAIT = 4'd5;
    localparam logic [3:0] S_B_GO    = 4'd6;
    localparam logic [3:0] S_B_WAIT  = 4'd7;
    localparam logic [3:0] S_Q_GO    = 4'd8;
    localparam logic [3:0] S_Q_WAIT1 = 4'd9;
    localparam logic [3:0] S_Q_WAIT2 = 4'd10;
    localparam logic [3:0] S_RESP    = 4'd11;

    logic [3:0]  state_reg;
    residue_t    modulus_reg;
    logic        ready_reg;
    logic [AW-1:0] idx_reg;
    residue_t    ival_reg;
    residue_t    prev_reg;
    residue_t    acc_reg;
    residue_t    base_reg;
    residue_t    exp_reg;
    logic [AW-1:0] nk_reg;
    residue_t    coef_reg;
    logic        status_reg;
    logic        m_tvalid_reg;
    residue_t    m_coef_reg;
    logic        m_status_reg;

    residue_t    fact_mem [TABLE_DEPTH];
    residue_t    inv_mem  [TABLE_DEPTH];
    residue_t    fact_q;
    residue_t    inv_q;

    logic        in_fire;
    logic [FIELD_W-1:0] k_in;
    logic [FIELD_W-1:0] n_in;
    logic        n_ok;
    residue_t    one_val;
    residue_t    ival_inc;
    residue_t    ival_dec;

    logic        fact_we;
    logic [AW-1:0] fact_waddr;
    residue_t    fact_wdata;
    logic        inv_we;
    logic [AW-1:0] inv_waddr;
    residue_t    inv_wdata;
    logic        fact_re;
    logic        inv_re;
    logic [AW-1:0] fact_raddr;
    logic [AW-1:0] inv_raddr;

    logic        mul_start;
    residue_t    mul_a;
    residue_t    mul_b;
    residue_t    mul_res;
    logic        mul_done;

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign k_in     = s_tdata[FIELD_W-1:0];
    assign n_in     = s_tdata[2*FIELD_W-1:FIELD_W];
    assign n_ok     = 32'(n_in) < 32'(TABLE_DEPTH);
    assign one_val  = (modulus_reg < MOD_W'(2)) ? '0 : MOD_W'(1);
    assign ival_inc = ((ival_reg + MOD_W'(1)) == modulus_reg) ? '0 : ival_reg + MOD_W'(1);
    assign ival_dec = (ival_reg == '0) ? modulus_reg - MOD_W'(1) : ival_reg - MOD_W'(1);

    ftbm_modmul u_modmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .m       (modulus_reg),
        .result  (mul_res),
        .done    (mul_done)
    );

    always_comb begin
        mul_start = 1'b0;
        mul_a     = prev_reg;
        mul_b     = ival_reg;
        unique case (state_reg)
            S_F_GO, S_B_GO: begin
                mul_start = 1'b1;
            end
            S_P_CHK: begin
                mul_start = (exp_reg != '0);
                mul_a     = exp_reg[0] ? acc_reg : base_reg;
                mul_b     = base_reg;
            end
            S_P_MWAIT: begin
                mul_start = mul_done;
                mul_a     = base_reg;
                mul_b     = base_reg;
            end
            S_Q_GO: begin
                mul_start = 1'b1;
                mul_a     = fact_q;
                mul_b     = inv_q;
            end
            S_Q_WAIT1: begin
                mul_start = mul_done;
                mul_a     = mul_res;
                mul_b     = inv_q;
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    // memory port control
    always_comb begin
        fact_we    = 1'b0;
        fact_waddr = idx_reg;
        fact_wdata = mul_res;
        inv_we     = 1'b0;
        inv_waddr  = idx_reg - AW'(1);
        inv_wdata  = mul_res;
        fact_re    = 1'b0;
        inv_re     = 1'b0;
        fact_raddr = AW'(n_in);
        inv_raddr  = AW'(k_in);
        if (state_reg == S_IDLE && in_fire && s_tuser == ACT_PREPARE) begin
            fact_we    = 1'b1;
            fact_waddr = '0;
            fact_wdata = one_val;
        end
        if (state_reg == S_F_WAIT && mul_done) begin
            fact_we = 1'b1;
        end
        if (state_reg == S_P_CHK && exp_reg == '0) begin
            inv_we    = 1'b1;
            inv_waddr = LAST_IDX;
            inv_wdata = acc_reg;
        end
        if (state_reg == S_B_WAIT && mul_done) begin
            inv_we = 1'b1;
        end
        if (state_reg == S_IDLE && in_fire && s_tuser == ACT_QUERY) begin
            fact_re = 1'b1;
            inv_re  = 1'b1;
        end
        if (state_reg == S_Q_GO) begin
            inv_re    = 1'b1;
            inv_raddr = nk_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fact_we) begin
            fact_mem[fact_waddr] <= fact_wdata;
        end
        if (fact_re) begin
            fact_q <= fact_mem[fact_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (inv_we) begin
            inv_mem[inv_waddr] <= inv_wdata;
        end
        if (inv_re) begin
            inv_q <= inv_mem[inv_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            modulus_reg  <= MODULUS_RESET;
            ready_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            idx_reg      <= '0;
        end else begin
            if (cfg_wen) begin
                modulus_reg <= cfg_wdata;
                ready_reg   <= 1'b0;
            end
            if (m_tvalid_reg && m_tready && state_reg != S_RESP) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (in_fire) begin
                        coef_reg   <= '0;
                        status_reg <= STATUS_OK;
                        if (s_tuser == ACT_PREPARE) begin
                            prev_reg  <= one_val;
                            idx_reg   <= AW'(1);
                            ival_reg  <= (modulus_reg == MOD_W'(1)) ? '0 : MOD_W'(1);
                            state_reg <= S_F_GO;
                        end else if (!ready_reg) begin
                            status_reg <= STATUS_NOT_READY;
                            state_reg  <= S_RESP;
                        end else if (k_in <= n_in && n_ok) begin
                            nk_reg    <= AW'(n_in - k_in);
                            state_reg <= S_Q_GO;
                        end else begin
                            state_reg <= S_RESP;
                        end
                    end
                end
                S_F_GO: begin
                    state_reg <= S_F_WAIT;
                end
                S_F_WAIT: begin
                    if (mul_done) begin
                        prev_reg <= mul_res;
                        if (idx_reg == LAST_IDX) begin
                            acc_reg   <= one_val;
                            base_reg  <= mul_res;
                            exp_reg   <= (modulus_reg >= MOD_W'(2)) ?
                                         modulus_reg - MOD_W'(2) : '0;
                            state_reg <= S_P_CHK;
                        end else begin
                            idx_reg   <= idx_reg + AW'(1);
                            ival_reg  <= ival_inc;
                            state_reg <= S_F_GO;
                        end
                    end
                end
                S_P_CHK: begin
                    if (exp_reg == '0) begin
                        prev_reg  <= acc_reg;
                        idx_reg   <= LAST_IDX;
                        state_reg <= S_B_GO;
                    end else if (exp_reg[0]) begin
                        state_reg <= S_P_MWAIT;
                    end else begin
                        state_reg <= S_P_SWAIT;
                    end
                end
                S_P_MWAIT: begin
                    if (mul_done) begin
                        acc_reg   <= mul_res;
                        state_reg <= S_P_SWAIT;
                    end
                end
                S_P_SWAIT: begin
                    if (mul_done) begin
                        base_reg  <= mul_res;
                        exp_reg   <= exp_reg >> 1;
                        state_reg <= S_P_CHK;
                    end
                end
                S_B_GO: begin
                    state_reg <= S_B_WAIT;
                end
                S_B_WAIT: begin
                    if (mul_done) begin
                        prev_reg <= mul_res;
                        if (idx_reg == AW'(1)) begin
                            ready_reg <= 1'b1;
                            state_reg <= S_RESP;
                        end else begin
                            idx_reg   <= idx_reg - AW'(1);
                            ival_reg  <= ival_dec;
                            state_reg <= S_B_GO;
                        end
                    end
                end
                S_Q_GO: begin
                    state_reg <= S_Q_WAIT1;
                end
                S_Q_WAIT1: begin
                    if (mul_done) begin
                        state_reg <= S_Q_WAIT2;
                    end
                end
                S_Q_WAIT2: begin
                    if (mul_done) begin
                        coef_reg  <= mul_res;
                        state_reg <= S_RESP;
                    end
                end
                S_RESP: begin
                    // hand off once the output beat is free
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_coef_reg   <= coef_reg;
                        m_status_reg <= status_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_coef_reg};
    assign m_tuser  = m_status_reg;

endmodule

// ===== hw/rtl/ftbm_modmul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftbm_modmul
// Bit-serial interleaved modular multiplier, one bit of b per cycle, msb first.
// ----------------------------------------------------------------------------
module ftbm_modmul (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  ftbm_pkg::residue_t a,
    input  ftbm_pkg::residue_t b,
    input  ftbm_pkg::residue_t m,
    output ftbm_pkg::residue_t result,
    output logic              done
);
    import ftbm_pkg::*;

    localparam int CNT_W = $clog2(MOD_W);

    residue_t         a_reg;
    residue_t         b_reg;
    residue_t         r_reg;
    residue_t         r_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [MOD_W:0] m_ext;
    logic [MOD_W:0] dbl;
    logic [MOD_W:0] dbl_red;
    logic [MOD_W:0] sum;
    logic [MOD_W:0] sum_red;

    // operands are below m, so each partial stays below 2m
    always_comb begin
        m_ext   = {1'b0, m};
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
        sum     = dbl_red + (b_reg[MOD_W-1] ? {1'b0, a_reg} : '0);
        sum_red = (sum >= m_ext) ? sum - m_ext : sum;
        r_next  = sum_red[MOD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            a_reg    <= '0;
            b_reg    <= '0;
            r_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                a_reg    <= a;
                b_reg    <= b;
                r_reg    <= '0;
            end else if (busy_reg) begin
                r_reg   <= r_next;
                b_reg   <= {b_reg[MOD_W-2:0], 1'b0};
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(MOD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign result = (m < MOD_W'(2)) ? '0 : r_reg;
    assign done   = done_reg;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Binomial coefficient core: directed and random prepare/query beats over
// several moduli, checked against a behavioral predictor of the tables.
// ----------------------------------------------------------------------------
module testbench;
    import ftbm_pkg::*;

    localparam int DEPTH       = 1024;
    localparam int IDLE_LIMIT  = 500000;
    localparam int LONG_HOLD   = 400;

    typedef struct packed {
        logic               action;
        logic [FIELD_W-1:0] k;
        logic [FIELD_W-1:0] n;
    } request_t;

    typedef struct packed {
        residue_t coef;
        logic     status;
    } answer_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wen = 1'b0;
    logic [30:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    factorial_table_binomial_mod_core #(.TABLE_DEPTH(DEPTH)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    request_t pending_beats[$];
    answer_t  expected_answers[$];
    int       error_count = 0;
    bit       quiet = 0;
    bit       long_hold_req = 0;
    bit       in_fire = 0;

    // predictor state
    residue_t pred_modulus = MODULUS_RESET;
    residue_t pred_fact[DEPTH];
    residue_t pred_inv_fact[DEPTH];
    bit       pred_ready = 0;

    function automatic residue_t reduce_mod(longint unsigned x);
        if (pred_modulus < 2) return '0;
        return residue_t'(x % longint'(pred_modulus));
    endfunction

    function automatic residue_t mul_mod(residue_t a, residue_t b);
        return reduce_mod(longint'(a) * longint'(b));
    endfunction

    function automatic residue_t pow_mod(residue_t base, logic [31:0] e);
        residue_t acc;
        residue_t b;
        acc = reduce_mod(1);
        b = reduce_mod(base);
        while (e != 0) begin
            if (e[0]) acc = mul_mod(acc, b);
            b = mul_mod(b, b);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic void build_tables();
        logic [31:0] e;
        pred_fact[0] = reduce_mod(1);
        for (int i = 1; i < DEPTH; i++)
            pred_fact[i] = mul_mod(pred_fact[i-1], reduce_mod(i));
        e = (pred_modulus >= 2) ? pred_modulus - 2 : 0;
        pred_inv_fact[DEPTH-1] = pow_mod(pred_fact[DEPTH-1], e);
        for (int i = DEPTH - 1; i > 0; i--)
            pred_inv_fact[i-1] = mul_mod(pred_inv_fact[i], reduce_mod(i));
        pred_ready = 1;
    endfunction

    function automatic answer_t predict_answer(request_t r);
        answer_t a;
        a.coef = '0;
        a.status = STATUS_OK;
        if (r.action == ACT_PREPARE) build_tables();
        else if (!pred_ready) a.status = STATUS_NOT_READY;
        else if (r.k <= r.n)
            a.coef = mul_mod(mul_mod(pred_fact[r.n], pred_inv_fact[r.k]),
                             pred_inv_fact[r.n - r.k]);
        return a;
    endfunction

    // predictor and checker at the rising edge
    always @(posedge aclk) begin
        answer_t  exp_a;
        request_t r;
        if (aresetn) begin
            if (cfg_wen) begin
                pred_modulus = cfg_wdata;
                pred_ready = 0;
            end
            if (s_tvalid && s_tready) begin
                r.action = s_tuser;
                r.k = s_tdata[9:0];
                r.n = s_tdata[19:10];
                exp_a = predict_answer(r);
                expected_answers = {expected_answers, exp_a};
            end
            if (m_tvalid && m_tready) begin
                if (expected_answers.size() == 0) begin
                    $error("result beat with no expectation: coefficient %0d status %0d",
                           m_tdata[30:0], m_tuser);
                    error_count++;
                end else begin
                    exp_a = expected_answers.pop_front();
                    if (m_tdata[30:0] !== exp_a.coef) begin
                        $error("coefficient: expected %0d actual %0d", exp_a.coef,
                               m_tdata[30:0]);
                        error_count++;
                    end
                    if (m_tuser !== exp_a.status) begin
                        $error("status: expected %0d actual %0d", exp_a.status, m_tuser);
                        error_count++;
                    end
                end
            end
        end
        in_fire <= s_tvalid && s_tready;
    end

    // sender
    int send_gap = 0;
    always @(negedge aclk) begin
        request_t r;
        logic     next_valid;
        next_valid = s_tvalid && !in_fire;
        if (aresetn && (!s_tvalid || in_fire)) begin
            next_valid = 0;
            if (send_gap > 0) send_gap--;
            else if (pending_beats.size() > 0) begin
                r = pending_beats.pop_front();
                s_tdata <= {4'b0, r.n, r.k};
                s_tuser <= r.action;
                next_valid = 1;
                if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 10);
            end
        end
        s_tvalid <= next_valid;
    end

    // receiver
    int recv_gap = 0;
    int hold_count = 0;
    always @(negedge aclk) begin
        logic ready;
        ready = 1;
        if (long_hold_req) begin
            long_hold_req = 0;
            hold_count = LONG_HOLD;
        end
        if (hold_count > 0) begin
            hold_count--;
            ready = 0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            ready = 0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            recv_gap = $urandom_range(1, 10);
            ready = 0;
        end
        m_tready <= aresetn && ready;
    end

    // watchdog on cycles without any accepted beat
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic add_beat(logic act, int k, int n);
        request_t r;
        r.action = act;
        r.k = FIELD_W'(k);
        r.n = FIELD_W'(n);
        pending_beats = {pending_beats, r};
    endtask

    task automatic add_random_queries(int count);
        int n;
        int k;
        repeat (count) begin
            n = $urandom_range(0, 1023);
            if ($urandom_range(0, 4) == 0) k = $urandom_range(0, 1023);
            else k = $urandom_range(0, n);
            add_beat(ACT_QUERY, k, n);
        end
    endtask

    task automatic drain();
        while (pending_beats.size() != 0 || s_tvalid || expected_answers.size() != 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_modulus(logic [30:0] value);
        @(negedge aclk);
        cfg_wdata <= value;
        cfg_wen <= 1'b1;
        @(negedge aclk);
        cfg_wen <= 1'b0;
    endtask

    // write the modulus, one query before prepare, prepare with random ignored fields, then random queries
    task automatic modulus_phase(logic [30:0] value, int count);
        write_modulus(value);
        add_beat(ACT_QUERY, $urandom_range(0, 1023), $urandom_range(0, 1023));
        add_beat(ACT_PREPARE, $urandom_range(0, 1023), $urandom_range(0, 1023));
        add_random_queries(count);
        drain();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part on the reset modulus
        add_beat(ACT_QUERY, 0, 0);
        add_beat(ACT_QUERY, 1023, 1023);
        add_beat(ACT_PREPARE, 1023, 1023);
        add_beat(ACT_QUERY, 0, 0);
        add_beat(ACT_QUERY, 1023, 1023);
        add_beat(ACT_QUERY, 0, 1023);
        add_beat(ACT_QUERY, 1023, 0);
        add_beat(ACT_QUERY, 1, 0);
        add_beat(ACT_QUERY, 512, 1023);
        add_beat(ACT_QUERY, 1, 1023);
        add_beat(ACT_QUERY, 341, 682);
        add_beat(ACT_QUERY, 682, 341);
        add_random_queries(150);
        // receiver holds off while the sender keeps offering beats
        while (expected_answers.size() < 1) @(posedge aclk);
        long_hold_req = 1;
        drain();

        modulus_phase(31'h7FFF_FFFF, 100);
        modulus_phase(31'd2, 90);
        modulus_phase(31'd1000, 90);
        quiet = 1;
        modulus_phase(31'd1031, 100);

        drain();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
